// ----- hdl/edf_task_ready_queue_macros.svh -----
// Assertion macros for the EDF task ready queue checker.
// Used by the checker file only; depends on nothing else.
`ifndef EDF_TASK_READY_QUEUE_MACROS_SVH
`define EDF_TASK_READY_QUEUE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ETRQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ETRQ_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/etrq_pkg.sv -----
// Shared types and constants of the EDF task ready queue.
// Used by the cell, the controller and the top level; depends on nothing.
`default_nettype none

package etrq_pkg;

   // Default parameter values.
   localparam int MAX_TASKS_DEF    = 32;
   localparam int NUM_QUEUES_DEF   = 4;
   localparam int EDF_QUEUE_DEF    = 0;
   localparam int TASK_ID_BITS_DEF = 8;

   // Fixed field widths.
   localparam int KEY_W    = 63;
   localparam int SQ_W     = 2;
   localparam int DL_W     = 32;
   localparam int PORT_ID_W = 8;
   localparam int QINDEX_W = 3;

   // Reset value of the fallback deadline register (one second in ns).
   localparam logic [DL_W-1:0] DEADLINE_RESET = 32'd1000000000;

   typedef enum logic {
      CMD_ENQUEUE = 1'b0,
      CMD_DEQUEUE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FALLBACK  = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_APPEND = 2'd1,
      OP_REMOVE = 2'd2,
      OP_ROTATE = 2'd3
   } cell_op_type;

   typedef enum logic [2:0] {
      S_IDLE   = 3'd0,
      S_FIND   = 3'd1,
      S_REMOVE = 3'd2,
      S_APPEND = 3'd3,
      S_SCAN   = 3'd4,
      S_RESULT = 3'd5
   } state_type;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      cell_op_type      op;
      logic [KEY_W-1:0] key;
      logic [SQ_W-1:0]  sq;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ----- hdl/etrq_cell.sv -----
// One slot of the task table: valid flag, task id, key and sub-queue.
// Depends on etrq_pkg for the cell command struct.
`default_nettype none

module etrq_cell #(
   parameter int TASK_ID_BITS = etrq_pkg::TASK_ID_BITS_DEF,
   parameter int CNT_W        = 6,
   parameter int INDEX        = 0
) (
   input  wire                           clock,
   input  wire                           reset,
   input  etrq_pkg::cell_ctrl_type       ctrl,
   input  wire [TASK_ID_BITS-1:0]        new_tid,
   input  wire [CNT_W-1:0]               mark,
   input  wire                           right_valid,
   input  wire [TASK_ID_BITS-1:0]        right_tid,
   input  wire [etrq_pkg::KEY_W-1:0]     right_key,
   input  wire [etrq_pkg::SQ_W-1:0]      right_sq,
   output logic                          valid,
   output logic [TASK_ID_BITS-1:0]       tid,
   output logic [etrq_pkg::KEY_W-1:0]    key,
   output logic [etrq_pkg::SQ_W-1:0]     sq
);

   localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

   logic                         valid_ff, valid_in;
   logic [TASK_ID_BITS-1:0]      tid_ff, tid_in;
   logic [etrq_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [etrq_pkg::SQ_W-1:0]    sq_ff, sq_in;

   // Append loads the slot at the fill mark, remove shifts down every slot at or
   // above the removed one, and rotate passes the whole row one step toward the head.
   always_comb begin
      valid_in = valid_ff;
      tid_in   = tid_ff;
      key_in   = key_ff;
      sq_in    = sq_ff;
      unique case (ctrl.op)
         etrq_pkg::OP_APPEND: begin
            if (MY_INDEX == mark) begin
               valid_in = 1'b1;
               tid_in   = new_tid;
               key_in   = ctrl.key;
               sq_in    = ctrl.sq;
            end
         end
         etrq_pkg::OP_REMOVE: begin
            if (MY_INDEX >= mark) begin
               valid_in = right_valid;
               tid_in   = right_tid;
               key_in   = right_key;
               sq_in    = right_sq;
            end
         end
         etrq_pkg::OP_ROTATE: begin
            valid_in = right_valid;
            tid_in   = right_tid;
            key_in   = right_key;
            sq_in    = right_sq;
         end
         etrq_pkg::OP_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   // Only the valid flag needs a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tid_ff <= tid_in;
      key_ff <= key_in;
      sq_ff  <= sq_in;
   end

   assign valid = valid_ff;
   assign tid   = tid_ff;
   assign key   = key_ff;
   assign sq    = sq_ff;

endmodule

`default_nettype wire

// ----- hdl/etrq_ctrl.sv -----
// Controller of the ready queue: request capture, key forming, sequencing
// of the cell row and the least-key search at the head cell.
// Depends on etrq_pkg.
`default_nettype none

module etrq_ctrl #(
   parameter int MAX_TASKS    = etrq_pkg::MAX_TASKS_DEF,
   parameter int NUM_QUEUES   = etrq_pkg::NUM_QUEUES_DEF,
   parameter int EDF_QUEUE    = etrq_pkg::EDF_QUEUE_DEF,
   parameter int TASK_ID_BITS = etrq_pkg::TASK_ID_BITS_DEF,
   localparam int CNT_W       = $clog2(MAX_TASKS + 1),
   localparam int STEP_W      = $clog2(MAX_TASKS)
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire                               req_command,
   input  wire [etrq_pkg::PORT_ID_W-1:0]     req_task_id,
   input  wire [etrq_pkg::QINDEX_W-1:0]      req_queue_index,
   input  wire [etrq_pkg::DL_W-1:0]          req_relative_deadline,
   input  wire [etrq_pkg::KEY_W-1:0]         req_key_value,
   input  wire [etrq_pkg::KEY_W-1:0]         req_time_now,
   input  wire                               csr_write_enable,
   input  wire [etrq_pkg::DL_W-1:0]          csr_write_data,
   output logic                              rsp_strobe,
   output logic [etrq_pkg::SQ_W-1:0]         rsp_queue_used,
   output logic                              rsp_best_valid,
   output logic [etrq_pkg::PORT_ID_W-1:0]    rsp_best_task_id,
   output logic [1:0]                        rsp_status,
   output etrq_pkg::cell_ctrl_type           cell_ctrl,
   output logic [TASK_ID_BITS-1:0]           cell_tid,
   output logic [CNT_W-1:0]                  cell_mark,
   input  wire                               head_valid,
   input  wire [TASK_ID_BITS-1:0]            head_tid,
   input  wire [etrq_pkg::KEY_W-1:0]         head_key,
   input  wire [etrq_pkg::SQ_W-1:0]          head_sq
);

   localparam logic [etrq_pkg::SQ_W-1:0]     EDF_Q     = etrq_pkg::SQ_W'(EDF_QUEUE);
   localparam logic [etrq_pkg::QINDEX_W-1:0] NQ        = etrq_pkg::QINDEX_W'(NUM_QUEUES);
   localparam logic [CNT_W-1:0]              CNT_FULL  = CNT_W'(MAX_TASKS);
   localparam logic [STEP_W-1:0]             STEP_LAST = STEP_W'(MAX_TASKS - 1);

   etrq_pkg::state_type             state_ff, state_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [STEP_W-1:0]               step_ff, step_in;
   logic                            found_ff, found_in;
   logic                            bvalid_ff, bvalid_in;
   logic [etrq_pkg::DL_W-1:0]       fallback_ff, fallback_in;
   logic [STEP_W-1:0]               pos_ff, pos_in;
   logic [TASK_ID_BITS-1:0]         tid_ff, tid_in;
   logic [etrq_pkg::SQ_W-1:0]       sq_ff, sq_in;
   logic [etrq_pkg::KEY_W-1:0]      key_ff, key_in;
   etrq_pkg::status_type            status_ff, status_in;
   logic [TASK_ID_BITS-1:0]         best_ff, best_in;
   logic [etrq_pkg::KEY_W-1:0]      bkey_ff, bkey_in;

   logic                            accept;
   logic [TASK_ID_BITS+7:0]         req_tid_ext;
   logic [TASK_ID_BITS-1:0]         req_tid;
   logic                            qvalid;
   logic [etrq_pkg::SQ_W-1:0]       req_sq;
   logic [etrq_pkg::DL_W-1:0]       rel;
   logic [etrq_pkg::KEY_W:0]        sum;
   logic [etrq_pkg::KEY_W-1:0]      key_sat;
   logic [etrq_pkg::KEY_W-1:0]      req_key;
   logic                            full;
   logic                            last_step;
   logic                            head_hit;
   logic                            head_better;
   logic [TASK_ID_BITS+7:0]         best_ext;

   // Request decode: id masking, sub-queue resolution and the EDF key.
   assign accept      = start && (state_ff == etrq_pkg::S_IDLE);
   assign req_tid_ext = {{TASK_ID_BITS{1'b0}}, req_task_id};
   assign req_tid     = req_tid_ext[TASK_ID_BITS-1:0];
   assign qvalid      = req_queue_index < NQ;
   assign req_sq      = qvalid ? req_queue_index[etrq_pkg::SQ_W-1:0] : EDF_Q;
   assign rel         = qvalid ? req_relative_deadline : fallback_ff;
   assign sum         = {1'b0, req_time_now} + {{(etrq_pkg::KEY_W + 1 - etrq_pkg::DL_W){1'b0}}, rel};
   assign key_sat     = sum[etrq_pkg::KEY_W] ? {etrq_pkg::KEY_W{1'b1}} : sum[etrq_pkg::KEY_W-1:0];
   assign req_key     = (req_sq == EDF_Q) ? key_sat : req_key_value;

   // Head cell checks during the rotation passes.
   assign full        = count_ff == CNT_FULL;
   assign last_step   = step_ff == STEP_LAST;
   assign head_hit    = head_valid && (head_tid == tid_ff);
   assign head_better = head_valid && (head_sq == sq_ff) && (!bvalid_ff || (head_key < bkey_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         etrq_pkg::S_IDLE: begin
            if (accept) begin
               if (etrq_pkg::cmd_type'(req_command) == etrq_pkg::CMD_DEQUEUE) begin
                  state_in = etrq_pkg::S_FIND;
               end else if (full) begin
                  state_in = etrq_pkg::S_SCAN;
               end else begin
                  state_in = etrq_pkg::S_APPEND;
               end
            end
         end
         etrq_pkg::S_FIND: begin
            if (last_step) begin
               state_in = (found_ff || head_hit) ? etrq_pkg::S_REMOVE : etrq_pkg::S_SCAN;
            end
         end
         etrq_pkg::S_REMOVE: begin
            state_in = etrq_pkg::S_SCAN;
         end
         etrq_pkg::S_APPEND: begin
            state_in = etrq_pkg::S_SCAN;
         end
         etrq_pkg::S_SCAN: begin
            if (last_step) begin
               state_in = etrq_pkg::S_RESULT;
            end
         end
         etrq_pkg::S_RESULT: begin
            state_in = etrq_pkg::S_IDLE;
         end
         default: begin
            state_in = etrq_pkg::S_IDLE;
         end
      endcase
   end

   // Outputs decoded from the state.
   always_comb begin
      busy          = state_ff != etrq_pkg::S_IDLE;
      rsp_strobe    = state_ff == etrq_pkg::S_RESULT;
      cell_ctrl.op  = etrq_pkg::OP_HOLD;
      cell_ctrl.key = key_ff;
      cell_ctrl.sq  = sq_ff;
      cell_mark     = count_ff;
      unique case (state_ff)
         etrq_pkg::S_FIND,
         etrq_pkg::S_SCAN: begin
            cell_ctrl.op = etrq_pkg::OP_ROTATE;
         end
         etrq_pkg::S_REMOVE: begin
            cell_ctrl.op = etrq_pkg::OP_REMOVE;
            cell_mark    = CNT_W'(pos_ff);
         end
         etrq_pkg::S_APPEND: begin
            cell_ctrl.op = etrq_pkg::OP_APPEND;
         end
         etrq_pkg::S_IDLE,
         etrq_pkg::S_RESULT: begin
            cell_ctrl.op = etrq_pkg::OP_HOLD;
         end
         default: begin
            cell_ctrl.op = etrq_pkg::OP_HOLD;
         end
      endcase
   end

   assign cell_tid         = tid_ff;
   assign best_ext         = {{etrq_pkg::PORT_ID_W{1'b0}}, best_ff};
   assign rsp_queue_used   = sq_ff;
   assign rsp_best_valid   = bvalid_ff;
   assign rsp_best_task_id = bvalid_ff ? best_ext[etrq_pkg::PORT_ID_W-1:0] : '0;
   assign rsp_status       = status_ff;

   // Datapath next values.
   always_comb begin
      count_in    = count_ff;
      step_in     = '0;
      found_in    = found_ff;
      bvalid_in   = bvalid_ff;
      fallback_in = fallback_ff;
      pos_in      = pos_ff;
      tid_in      = tid_ff;
      sq_in       = sq_ff;
      key_in      = key_ff;
      status_in   = status_ff;
      best_in     = best_ff;
      bkey_in     = bkey_ff;

      if (csr_write_enable) begin
         fallback_in = csr_write_data;
      end

      // Capture the request; the dequeue status is settled by the search.
      if (accept) begin
         tid_in    = req_tid;
         sq_in     = req_sq;
         key_in    = req_key;
         found_in  = 1'b0;
         bvalid_in = 1'b0;
         if (etrq_pkg::cmd_type'(req_command) == etrq_pkg::CMD_DEQUEUE) begin
            status_in = etrq_pkg::ST_OK;
         end else if (full) begin
            status_in = etrq_pkg::ST_FULL;
         end else if (qvalid) begin
            status_in = etrq_pkg::ST_OK;
         end else begin
            status_in = etrq_pkg::ST_FALLBACK;
         end
      end

      // Rotation step counter.
      if ((state_ff == etrq_pkg::S_FIND) || (state_ff == etrq_pkg::S_SCAN)) begin
         step_in = last_step ? '0 : step_ff + 1'b1;
      end

      // Id search: remember the first slot that holds the id.
      if (state_ff == etrq_pkg::S_FIND) begin
         if (head_hit && !found_ff) begin
            found_in = 1'b1;
            pos_in   = step_ff;
            sq_in    = head_sq;
         end
         if (last_step && !found_ff && !head_hit) begin
            status_in = etrq_pkg::ST_NOT_FOUND;
         end
      end

      if (state_ff == etrq_pkg::S_APPEND) begin
         count_in = count_ff + 1'b1;
      end

      if (state_ff == etrq_pkg::S_REMOVE) begin
         count_in = count_ff - 1'b1;
      end

      // Least-key search; strict compare keeps the earliest of equal keys.
      if ((state_ff == etrq_pkg::S_SCAN) && head_better) begin
         bvalid_in = 1'b1;
         best_in   = head_tid;
         bkey_in   = head_key;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= etrq_pkg::S_IDLE;
         count_ff    <= '0;
         step_ff     <= '0;
         found_ff    <= 1'b0;
         bvalid_ff   <= 1'b0;
         fallback_ff <= etrq_pkg::DEADLINE_RESET;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         step_ff     <= step_in;
         found_ff    <= found_in;
         bvalid_ff   <= bvalid_in;
         fallback_ff <= fallback_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      tid_ff    <= tid_in;
      sq_ff     <= sq_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      best_ff   <= best_in;
      bkey_ff   <= bkey_in;
   end

endmodule

`default_nettype wire

// ----- hdl/edf_task_ready_queue.sv -----
// Top level of the EDF task ready queue: controller and the row of table cells.
// Depends on etrq_pkg, etrq_cell and etrq_ctrl.
//
// The table is a row of MAX_TASKS cells kept packed in insertion order. A request
// is taken when start is high and busy is low; its result appears on the rsp_
// ports for exactly one cycle with rsp_strobe, and the receiver cannot stall it.
// Every report rotates the whole row once past a key comparator at the head cell,
// one cell per cycle, and a dequeue first rotates the row once more to find the id.
// An enqueue appends before its scan (a full-table enqueue scans at once), and a
// dequeue removes the task between its two rotations, or skips that step when the
// id is absent. No clearing pass is needed after reset. The fallback deadline may
// be written at any idle time and applies to the next request.
`default_nettype none

module edf_task_ready_queue #(
   parameter int MAX_TASKS    = etrq_pkg::MAX_TASKS_DEF,
   parameter int NUM_QUEUES   = etrq_pkg::NUM_QUEUES_DEF,
   parameter int EDF_QUEUE    = etrq_pkg::EDF_QUEUE_DEF,
   parameter int TASK_ID_BITS = etrq_pkg::TASK_ID_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               start,
   output logic                              busy,
   input  wire                               req_command,
   input  wire [etrq_pkg::PORT_ID_W-1:0]     req_task_id,
   input  wire [etrq_pkg::QINDEX_W-1:0]      req_queue_index,
   input  wire [etrq_pkg::DL_W-1:0]          req_relative_deadline,
   input  wire [etrq_pkg::KEY_W-1:0]         req_key_value,
   input  wire [etrq_pkg::KEY_W-1:0]         req_time_now,
   input  wire                               csr_write_enable,
   input  wire [etrq_pkg::DL_W-1:0]          csr_write_data,
   output logic                              rsp_strobe,
   output logic [etrq_pkg::SQ_W-1:0]         rsp_queue_used,
   output logic                              rsp_best_valid,
   output logic [etrq_pkg::PORT_ID_W-1:0]    rsp_best_task_id,
   output logic [1:0]                        rsp_status
);

   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   etrq_pkg::cell_ctrl_type         cell_ctrl;
   logic [TASK_ID_BITS-1:0]         cell_tid;
   logic [CNT_W-1:0]                cell_mark;

   // Slot outputs; the extra entry at MAX_TASKS feeds the last cell.
   logic                            valid_w [0:MAX_TASKS];
   logic [TASK_ID_BITS-1:0]         tid_w   [0:MAX_TASKS];
   logic [etrq_pkg::KEY_W-1:0]      key_w   [0:MAX_TASKS];
   logic [etrq_pkg::SQ_W-1:0]       sq_w    [0:MAX_TASKS];

   etrq_ctrl #(
      .MAX_TASKS    (MAX_TASKS),
      .NUM_QUEUES   (NUM_QUEUES),
      .EDF_QUEUE    (EDF_QUEUE),
      .TASK_ID_BITS (TASK_ID_BITS)
   ) u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_task_id           (req_task_id),
      .req_queue_index       (req_queue_index),
      .req_relative_deadline (req_relative_deadline),
      .req_key_value         (req_key_value),
      .req_time_now          (req_time_now),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .rsp_strobe            (rsp_strobe),
      .rsp_queue_used        (rsp_queue_used),
      .rsp_best_valid        (rsp_best_valid),
      .rsp_best_task_id      (rsp_best_task_id),
      .rsp_status            (rsp_status),
      .cell_ctrl             (cell_ctrl),
      .cell_tid              (cell_tid),
      .cell_mark             (cell_mark),
      .head_valid            (valid_w[0]),
      .head_tid              (tid_w[0]),
      .head_key              (key_w[0]),
      .head_sq               (sq_w[0])
   );

   // The last cell wraps to the head while rotating and shifts in an empty slot
   // on removal.
   assign valid_w[MAX_TASKS] = (cell_ctrl.op == etrq_pkg::OP_ROTATE) && valid_w[0];
   assign tid_w[MAX_TASKS]   = tid_w[0];
   assign key_w[MAX_TASKS]   = key_w[0];
   assign sq_w[MAX_TASKS]    = sq_w[0];

   // Row of table cells.
   for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
      etrq_cell #(
         .TASK_ID_BITS (TASK_ID_BITS),
         .CNT_W        (CNT_W),
         .INDEX        (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl),
         .new_tid     (cell_tid),
         .mark        (cell_mark),
         .right_valid (valid_w[i+1]),
         .right_tid   (tid_w[i+1]),
         .right_key   (key_w[i+1]),
         .right_sq    (sq_w[i+1]),
         .valid       (valid_w[i]),
         .tid         (tid_w[i]),
         .key         (key_w[i]),
         .sq          (sq_w[i])
      );
   end

endmodule

`default_nettype wire

// ----- hdl/etrq_checker.sv -----
// Port-level checks of the EDF task ready queue, bound to its top level.
// Depends on edf_task_ready_queue_macros.svh and edf_task_ready_queue.
`default_nettype none

`include "edf_task_ready_queue_macros.svh"

module etrq_checker (
   input wire       clock,
   input wire       reset,
   input wire       start,
   input wire       busy,
   input wire       rsp_strobe,
   input wire       rsp_best_valid,
   input wire [7:0] rsp_best_task_id
);

   // An accepted request keeps the block busy until its result.
   `ETRQ_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "request accepted without busy")

   // A result only appears while a request is in flight.
   `ETRQ_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe, busy, "result strobe while idle")

   // One result per request, then the block is free again.
   `ETRQ_ASSERT_NXT(a_strobe_done, clock, reset, rsp_strobe, !busy && !rsp_strobe, "block not free after result")

   // An empty sub-queue reports task id zero.
   `ETRQ_ASSERT_IMP(a_empty_id, clock, reset, rsp_strobe && !rsp_best_valid, rsp_best_task_id == 8'd0, "nonzero id for empty sub-queue")

endmodule

bind edf_task_ready_queue etrq_checker u_checker (.*);

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the EDF task ready queue (edf_task_ready_queue).
// It predicts each report from its own model of the task table in insertion order and checks it.
// Depends on etrq_pkg and the RTL of the block; reads no files.

module tb;
   import etrq_pkg::*;

   localparam int TABLE_DEPTH = MAX_TASKS_DEF;
   localparam int QUEUE_COUNT = NUM_QUEUES_DEF;
   localparam logic [SQ_W-1:0] EDF_SQ = SQ_W'(EDF_QUEUE_DEF);
   localparam int PHASE_COUNT = 9;
   localparam int PHASE_ITEMS = 160;
   // A dequeue rotates the row twice; allow that plus margin after the last report.
   localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 8;
   localparam int STALL_LIMIT = 4000;

   typedef struct packed {
      logic [PORT_ID_W-1:0] task_id;
      logic [KEY_W-1:0]     key;
      logic [SQ_W-1:0]      sq;
   } slot_entry_type;

   typedef struct packed {
      logic [SQ_W-1:0]      queue_used;
      logic                 best_valid;
      logic [PORT_ID_W-1:0] best_task_id;
      logic [1:0]           status;
   } ready_report_type;

   // Tracks the task table and the reports still owed by the block.
   class ready_queue_scoreboard;
      slot_entry_type   queued_tasks[$];
      ready_report_type owed_reports[$];
      logic [DL_W-1:0]  fallback_deadline;
      int               failures;

      function new();
         fallback_deadline = DEADLINE_RESET;
         failures = 0;
      endfunction

      function int pending();
         return owed_reports.size();
      endfunction

      function int occupancy();
         return queued_tasks.size();
      endfunction

      function logic [PORT_ID_W-1:0] random_queued_id();
         return queued_tasks[$urandom_range(0, queued_tasks.size() - 1)].task_id;
      endfunction

      // Least key of one sub-queue; a strict compare keeps the earliest among equals.
      function ready_report_type least_key_report(logic [SQ_W-1:0] sq, status_type st);
         ready_report_type r;
         bit found;
         logic [KEY_W-1:0] best_key;
         found = 1'b0;
         best_key = '0;
         r.queue_used = sq;
         r.best_task_id = '0;
         r.status = st;
         foreach (queued_tasks[i]) begin
            if (queued_tasks[i].sq == sq && (!found || queued_tasks[i].key < best_key)) begin
               found = 1'b1;
               best_key = queued_tasks[i].key;
               r.best_task_id = queued_tasks[i].task_id;
            end
         end
         r.best_valid = found;
         return r;
      endfunction

      // Applies one accepted request to the table and records the report it owes.
      function void note_request(cmd_type cmd, logic [PORT_ID_W-1:0] id,
                                 logic [QINDEX_W-1:0] qi, logic [DL_W-1:0] rel,
                                 logic [KEY_W-1:0] kv, logic [KEY_W-1:0] now);
         bit qvalid;
         logic [SQ_W-1:0] sq;
         status_type st;
         logic [KEY_W:0] sum;
         slot_entry_type e;
         int hit;
         qvalid = (qi < QUEUE_COUNT);
         sq = qvalid ? qi[SQ_W-1:0] : EDF_SQ;
         if (cmd == CMD_ENQUEUE) begin
            if (qvalid) begin
               st = ST_OK;
            end else begin
               st = ST_FALLBACK;
               rel = fallback_deadline;
            end
            e.task_id = id;
            e.sq = sq;
            if (sq == EDF_SQ) begin
               // Absolute deadline saturates at the largest key.
               sum = {1'b0, now} + (KEY_W + 1)'(rel);
               e.key = sum[KEY_W] ? '1 : sum[KEY_W-1:0];
            end else begin
               e.key = kv;
            end
            if (queued_tasks.size() >= TABLE_DEPTH) begin
               st = ST_FULL;
            end else begin
               queued_tasks.push_back(e);
            end
            owed_reports.push_back(least_key_report(sq, st));
         end else begin
            // The earliest entry with this id is the one removed.
            hit = -1;
            foreach (queued_tasks[i]) begin
               if (hit < 0 && queued_tasks[i].task_id == id) hit = i;
            end
            if (hit < 0) begin
               owed_reports.push_back(least_key_report(sq, ST_NOT_FOUND));
            end else begin
               sq = queued_tasks[hit].sq;
               queued_tasks.delete(hit);
               owed_reports.push_back(least_key_report(sq, ST_OK));
            end
         end
      endfunction

      function void compare_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            failures++;
         end
      endfunction

      // Compares one report with the oldest one owed.
      function void check_response(logic [SQ_W-1:0] qu, logic bv,
                                   logic [PORT_ID_W-1:0] id, logic [1:0] st);
         ready_report_type want;
         if (owed_reports.size() == 0) begin
            $error("report with no request outstanding: queue %0d task %0d status %0d",
                   qu, id, st);
            failures++;
            return;
         end
         want = owed_reports.pop_front();
         compare_field("queue_used", 8'(want.queue_used), 8'(qu));
         compare_field("best_valid", 8'(want.best_valid), 8'(bv));
         compare_field("best_task_id", want.best_task_id, id);
         compare_field("status", 8'(want.status), 8'(st));
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_command;
   logic [PORT_ID_W-1:0] req_task_id;
   logic [QINDEX_W-1:0]  req_queue_index;
   logic [DL_W-1:0]      req_relative_deadline;
   logic [KEY_W-1:0]     req_key_value;
   logic [KEY_W-1:0]     req_time_now;
   logic                 csr_write_enable;
   logic [DL_W-1:0]      csr_write_data;
   logic                 rsp_strobe;
   logic [SQ_W-1:0]      rsp_queue_used;
   logic                 rsp_best_valid;
   logic [PORT_ID_W-1:0] rsp_best_task_id;
   logic [1:0]           rsp_status;

   ready_queue_scoreboard sb;
   logic [KEY_W-1:0] clock_ns;
   int idle_cycles_ff = 0;

   edf_task_ready_queue dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_command           (req_command),
      .req_task_id           (req_task_id),
      .req_queue_index       (req_queue_index),
      .req_relative_deadline (req_relative_deadline),
      .req_key_value         (req_key_value),
      .req_time_now          (req_time_now),
      .csr_write_enable      (csr_write_enable),
      .csr_write_data        (csr_write_data),
      .rsp_strobe            (rsp_strobe),
      .rsp_queue_used        (rsp_queue_used),
      .rsp_best_valid        (rsp_best_valid),
      .rsp_best_task_id      (rsp_best_task_id),
      .rsp_status            (rsp_status)
   );

   always #5 clock = ~clock;

   // Reports are sampled at the edge that ends their cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         sb.check_response(rsp_queue_used, rsp_best_valid, rsp_best_task_id, rsp_status);
   end

   // Watchdog: ends the run after too many cycles with no request or report.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles_ff <= 0;
      end else if (idle_cycles_ff >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles_ff <= idle_cycles_ff + 1;
      end
   end

   // Presents one request and returns at the edge that accepts it.
   task automatic send_request(cmd_type cmd, logic [PORT_ID_W-1:0] id,
                               logic [QINDEX_W-1:0] qi, logic [DL_W-1:0] rel,
                               logic [KEY_W-1:0] kv, logic [KEY_W-1:0] now);
      req_command <= cmd;
      req_task_id <= id;
      req_queue_index <= qi;
      req_relative_deadline <= rel;
      req_key_value <= kv;
      req_time_now <= now;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(cmd, id, qi, rel, kv, now);
   endtask

   task automatic hold_off(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Waits until every owed report has arrived and the block is idle.
   task automatic settle();
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_fallback(logic [DL_W-1:0] value);
      csr_write_data <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      sb.fallback_deadline = value;
      csr_write_enable <= 1'b0;
   endtask

   // One random request; dequeues mostly name a task that is queued.
   task automatic send_random(int enqueue_pct, bit idling);
      cmd_type cmd;
      logic [PORT_ID_W-1:0] id;
      logic [QINDEX_W-1:0] qi;
      logic [DL_W-1:0] rel;
      logic [KEY_W-1:0] kv;
      logic [KEY_W-1:0] now;
      if ($urandom_range(0, 99) < enqueue_pct) cmd = CMD_ENQUEUE;
      else cmd = CMD_DEQUEUE;
      if ($urandom_range(0, 3) == 0) id = PORT_ID_W'($urandom);
      else id = PORT_ID_W'($urandom_range(0, 23));
      if (cmd == CMD_DEQUEUE && sb.occupancy() != 0 && $urandom_range(0, 4) != 0)
         id = sb.random_queued_id();
      if ($urandom_range(0, 4) == 0) qi = QINDEX_W'($urandom_range(4, 7));
      else qi = QINDEX_W'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
         0: rel = $urandom;
         1: rel = DL_W'($urandom_range(0, 3));
         default: rel = DL_W'($urandom_range(0, 5000));
      endcase
      case ($urandom_range(0, 3))
         0: kv = KEY_W'({$urandom, $urandom});
         1: kv = '1;
         default: kv = KEY_W'($urandom_range(0, 15));
      endcase
      // Time mostly runs forward; now and then it is random or near the top.
      clock_ns = clock_ns + KEY_W'($urandom_range(0, 2000));
      case ($urandom_range(0, 19))
         0: now = KEY_W'({$urandom, $urandom});
         1: now = '1 - KEY_W'($urandom_range(0, 5000));
         default: now = clock_ns;
      endcase
      send_request(cmd, id, qi, rel, kv, now);
      if (idling && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 10));
   endtask

   initial begin
      logic [DL_W-1:0] setting;
      int enqueue_pct;
      sb = new();
      clock_ns = '0;
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_ENQUEUE;
      req_task_id = '0;
      req_queue_index = '0;
      req_relative_deadline = '0;
      req_key_value = '0;
      req_time_now = '0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part with the fallback deadline at its reset value.
      // Empty table: absent ids on an invalid and on a valid sub-queue.
      send_request(CMD_DEQUEUE, 8'd5, 3'd7, '0, '0, '0);
      send_request(CMD_DEQUEUE, 8'd0, 3'd3, '0, '0, '0);
      // EDF keys at zero and at saturation, then an invalid sub-queue falls back.
      send_request(CMD_ENQUEUE, 8'd0, 3'd0, 32'd0, '0, '0);
      send_request(CMD_ENQUEUE, 8'd255, 3'd0, '1, '0, '1);
      send_request(CMD_ENQUEUE, 8'd7, 3'd5, 32'd17, '0, 63'd100);
      // Plain keys at both extremes, a tie, and a duplicate id on another queue.
      send_request(CMD_ENQUEUE, 8'd9, 3'd1, '0, '1, '0);
      send_request(CMD_ENQUEUE, 8'd10, 3'd1, '0, '0, '0);
      send_request(CMD_ENQUEUE, 8'd11, 3'd1, '0, '0, '0);
      send_request(CMD_ENQUEUE, 8'd10, 3'd2, '0, 63'd5, '0);
      send_request(CMD_ENQUEUE, 8'd12, 3'd3, '0, 63'd1, '0);
      // Duplicate removal goes oldest first, then the id is gone.
      send_request(CMD_DEQUEUE, 8'd10, 3'd6, '0, '0, '0);
      send_request(CMD_DEQUEUE, 8'd10, 3'd0, '0, '0, '0);
      send_request(CMD_DEQUEUE, 8'd10, 3'd2, '0, '0, '0);
      send_request(CMD_ENQUEUE, 8'd1, 3'd0, '1, '0, 63'd5);
      send_request(CMD_DEQUEUE, 8'd255, 3'd0, '0, '0, '0);
      send_request(CMD_DEQUEUE, 8'd0, 3'd4, '0, '0, '0);
      send_request(CMD_ENQUEUE, 8'd128, 3'd7, '0, '1, '1);
      send_request(CMD_DEQUEUE, 8'd200, 3'd1, '0, '0, '0);

      // Random phases; each starts idle with a new fallback deadline.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         settle();
         case (phase % 4)
            0: setting = '0;
            1: setting = '1;
            2: setting = $urandom;
            default: setting = DEADLINE_RESET;
         endcase
         write_fallback(setting);
         // Fill-heavy phases drive the table full, drain-heavy ones empty it.
         case (phase % 3)
            0: enqueue_pct = 55;
            1: enqueue_pct = 85;
            default: enqueue_pct = 25;
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_random(enqueue_pct, phase != PHASE_COUNT - 1);
      end

      // Drain, then allow for any stray report before deciding.
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/etrq_pkg.sv
hdl/etrq_cell.sv
hdl/etrq_ctrl.sv
hdl/edf_task_ready_queue.sv
hdl/etrq_checker.sv
tb/sv/tb.sv
